### design/risc_subset_instruction_executor_core_macros.svh
// assertion macros for the instruction executor core
// used by the top level only, expects clk and rst_n in scope
`ifndef RISC_SUBSET_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define RISC_SUBSET_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// same-cycle implication
`define RSIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rsie_pkg.sv
// shared types and constants for the instruction executor core
// no dependencies
package rsie_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int XLEN      = 32;
  localparam int PLEN_W    = 31;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;

  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_SRL = 6'd2;
  localparam logic [5:0] FN_SRA = 6'd3;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_OR  = 6'd35;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_SLT = 6'd42;

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_HALT    = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [XLEN-1:0]      wr_data;
    logic [XLEN-1:0]      pc_nxt;
    logic [XLEN-1:0]      read_value;
  } exec_res_t;

endpackage

### design/rsie_regfile.sv
// register file: flop array with one write and two registered read ports
// entries never written read as zero; depends on rsie_pkg
module rsie_regfile import rsie_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] rd_addr_a,
  input  logic [REG_IDX_W-1:0] rd_addr_b,
  output logic [XLEN-1:0]      rd_data_a,
  output logic [XLEN-1:0]      rd_data_b,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_addr,
  input  logic [XLEN-1:0]      wr_data
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [XLEN-1:0]      rd_data_a_r;
  logic [XLEN-1:0]      rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // bypass the write landing on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr_a) begin
        rd_data_a_r <= wr_data;
      end else begin
        rd_data_a_r <= valid_r[rd_addr_a] ? mem[rd_addr_a] : '0;
      end
      if (wr_en && wr_addr == rd_addr_b) begin
        rd_data_b_r <= wr_data;
      end else begin
        rd_data_b_r <= valid_r[rd_addr_b] ? mem[rd_addr_b] : '0;
      end
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

### design/rsie_exec.sv
// decode and execute of one item: alu, branch target and pc update
// depends on rsie_pkg
module rsie_exec import rsie_pkg::*; (
  input  logic              cmd,
  input  logic [XLEN-1:0]   instruction,
  input  logic [XLEN-1:0]   op_a,
  input  logic [XLEN-1:0]   op_b,
  input  logic [XLEN-1:0]   pc,
  input  logic [PLEN_W-1:0] program_length,
  output exec_res_t         res
);

  logic [5:0]           opcode;
  logic [5:0]           funct;
  logic [REG_IDX_W-1:0] rt;
  logic [REG_IDX_W-1:0] rd;
  logic [4:0]           sa;
  logic [XLEN-1:0]      imm;
  logic [XLEN-1:0]      br_off;
  logic                 past_end;
  logic                 taken;
  logic [XLEN-1:0]      pc_base;

  assign opcode   = instruction[31:26];
  assign rt       = instruction[20:16];
  assign rd       = instruction[15:11];
  assign sa       = instruction[10:6];
  assign funct    = instruction[5:0];
  assign imm      = {{16{instruction[15]}}, instruction[15:0]};
  assign br_off   = {imm[XLEN-3:0], 2'b00};
  assign past_end = {1'b0, pc[XLEN-1:2]} >= program_length;
  assign pc_base  = taken ? pc + br_off : pc;

  always_comb begin
    taken          = 1'b0;
    res.status     = ST_OK;
    res.wr_en      = 1'b0;
    res.wr_idx     = rd;
    res.wr_data    = '0;
    res.read_value = '0;
    res.pc_nxt     = pc;
    priority if (cmd == CMD_READ) begin
      res.read_value = op_a;
    end else if (past_end) begin
      res.status = ST_HALT;
    end else begin
      unique case (opcode)
        OP_ADDI: begin
          res.wr_en   = 1'b1;
          res.wr_idx  = rt;
          res.wr_data = op_a + imm;
        end
        OP_BEQ: begin
          taken = (op_a == op_b);
        end
        OP_BNE: begin
          taken = (op_a != op_b);
        end
        OP_SPECIAL: begin
          res.wr_en = 1'b1;
          unique case (funct)
            FN_ADD: res.wr_data = op_a + op_b;
            FN_AND: res.wr_data = op_a & op_b;
            FN_OR:  res.wr_data = op_a | op_b;
            FN_SLL: res.wr_data = op_b << sa;
            FN_SRL: res.wr_data = op_b >> sa;
            FN_SRA: res.wr_data = $unsigned($signed(op_b) >>> sa);
            FN_SLT: res.wr_data = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            default: begin
              res.wr_en  = 1'b0;
              res.status = ST_UNKNOWN;
            end
          endcase
        end
        default: begin
          res.status = ST_UNKNOWN;
        end
      endcase
      // register zero is never written
      if (res.wr_idx == '0) begin
        res.wr_en = 1'b0;
      end
      res.pc_nxt = pc_base + XLEN'(4);
    end
  end

endmodule

### design/risc_subset_instruction_executor_core.sv
// Instruction executor for an integer subset (ADDI, ADD, AND, OR, SLL, SRL, SRA,
// SLT, BEQ, BNE) with a 32-entry register file and a byte program counter.
// Throughput is one item per clock while out_ready is high. From acceptance to
// the result being offered, the accept edge captures the item and reads both
// source registers; a later edge executes, updates state and loads the result
// register. The register file read happens at accept with a bypass of the
// write retiring on that edge, so back-to-back dependent instructions run at
// full rate. Past the program end an execute item returns status halt and
// changes nothing; read items are always served. cfg_ready is always high.
// depends on rsie_pkg, rsie_regfile, rsie_exec and the assertion macro header
`include "risc_subset_instruction_executor_core_macros.svh"

module risc_subset_instruction_executor_core import rsie_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [XLEN-1:0]      in_instruction,
  input  logic [REG_IDX_W-1:0] in_read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [XLEN-1:0]      out_next_pc,
  output logic [XLEN-1:0]      out_read_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PLEN_W-1:0]    cfg_program_length
);

  logic                 in_valid_r;
  logic                 cmd_r;
  logic [XLEN-1:0]      instr_r;
  logic [XLEN-1:0]      pc_r;
  logic [PLEN_W-1:0]    prog_len_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [XLEN-1:0]      out_next_pc_r;
  logic [XLEN-1:0]      out_read_value_r;
  logic                 in_fire;
  logic                 exec_fire;
  logic [REG_IDX_W-1:0] rd_addr_a;
  logic [XLEN-1:0]      op_a;
  logic [XLEN-1:0]      op_b;
  exec_res_t            res;

  assign exec_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || exec_fire;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign rd_addr_a = (in_cmd == CMD_READ) ? in_read_index : in_instruction[25:21];

  rsie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_instruction[20:16]),
    .rd_data_a (op_a),
    .rd_data_b (op_b),
    .wr_en     (exec_fire && res.wr_en),
    .wr_addr   (res.wr_idx),
    .wr_data   (res.wr_data)
  );

  rsie_exec u_exec (
    .cmd            (cmd_r),
    .instruction    (instr_r),
    .op_a           (op_a),
    .op_b           (op_b),
    .pc             (pc_r),
    .program_length (prog_len_r),
    .res            (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      instr_r <= in_instruction;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      prog_len_r <= '0;
    end else begin
      if (exec_fire) begin
        pc_r <= res.pc_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        prog_len_r <= cfg_program_length;
      end
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r     <= res.status;
      out_next_pc_r    <= res.pc_nxt;
      out_read_value_r <= res.read_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_next_pc    = out_next_pc_r;
  assign out_read_value = out_read_value_r;

  `RSIE_ASSERT_NOW(a_no_r0_write, exec_fire && res.wr_en, res.wr_idx != '0, "write to register zero")
  `RSIE_ASSERT_NEXT(a_halt_keeps_pc, exec_fire && res.status == ST_HALT, $stable(pc_r), "pc moved on halt")
  `RSIE_ASSERT_NEXT(a_exec_loads_out, exec_fire, out_valid_r, "executed item lost")
  `RSIE_ASSERT_NOW(a_nonread_zero, out_valid_r && out_status_r != ST_OK, out_read_value_r == '0, "read value on non-ok item")

endmodule
